// ===== rtl/core/turbidity_spread_ratio_top_macros.svh =====
// ----------------------------------------------------------------------------
// turbidity spread ratio assertion macros
// shared property shorthands for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef TURBIDITY_SPREAD_RATIO_TOP_MACROS_SVH
`define TURBIDITY_SPREAD_RATIO_TOP_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define TSR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tsr assertion failed");

// next-cycle implication under synchronous active-low reset
`define TSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tsr assertion failed");

`endif

// ===== rtl/core/tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsr_pkg
// sizes, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

    // window and field sizes
    localparam int WINDOW   = 16;
    localparam int SAMPLE_W = 10;
    localparam int CFG_W    = 32;
    localparam int FRAC_W   = 16;

    // derived widths
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = $clog2(((1 << SAMPLE_W) - 1) * WINDOW + 1);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int AB_W   = SUM_W + CNT_W;
    localparam int D_W    = 2 * CNT_W;
    localparam int P_W    = AB_W + D_W;
    localparam int RAT_W  = P_W + FRAC_W;
    localparam int LO_W   = RAT_W / 2;
    localparam int HI_W   = RAT_W - LO_W;
    localparam int ACC_W  = CFG_W + RAT_W + 1;
    localparam int DCNT_W = $clog2(RAT_W + 1);

    // configuration register indexes
    localparam logic REG_CAL_SLOPE     = 1'b0;
    localparam logic REG_CAL_INTERCEPT = 1'b1;

    // reset values
    localparam logic [CFG_W-1:0] CAL_SLOPE_RST     = 32'h0001_0000;
    localparam logic [CFG_W-1:0] CAL_INTERCEPT_RST = 32'h0000_0000;

    // controller to datapath commands
    typedef struct packed {
        logic             wr;
        logic             scan_clr;
        logic             sum_en;
        logic             cls_en;
        logic [IDX_W-1:0] idx;
        logic             ab_en;
        logic             nd_en;
        logic             pq_en;
        logic             div_load;
        logic             div_step;
        logic             plo_en;
        logic             phi_en;
        logic             acc_en;
        logic             res_en;
        logic             out_load;
        logic             out_err;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic ok;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsr_dp.sv =====
// ----------------------------------------------------------------------------
// tsr_dp
// sample windows, spread accumulators, serial divider and calibration math
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tsr_pkg::cmd_t                 cmd,
    output tsr_pkg::sts_t                      sts,
    input  wire logic [tsr_pkg::SAMPLE_W-1:0]  s_side_sample,
    input  wire logic [tsr_pkg::SAMPLE_W-1:0]  s_through_sample,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [tsr_pkg::CFG_W-1:0]     cfg_data,
    output logic signed [tsr_pkg::CFG_W-1:0]   m_turbidity,
    output logic                               m_status
);

    localparam logic signed [tsr_pkg::ACC_W-1:0] SAT_HI =
        $signed({{(tsr_pkg::ACC_W-32){1'b0}}, 32'h7FFF_FFFF});
    localparam logic signed [tsr_pkg::ACC_W-1:0] SAT_LO =
        $signed({{(tsr_pkg::ACC_W-32){1'b1}}, 32'h8000_0000});

    // lane 0 is the side window, lane 1 the through window
    logic [tsr_pkg::SAMPLE_W-1:0] win_reg [2][tsr_pkg::WINDOW];
    logic [tsr_pkg::IDX_W-1:0]    slot_reg;

    logic signed [tsr_pkg::CFG_W-1:0] slope_reg;
    logic signed [tsr_pkg::CFG_W-1:0] icpt_reg;

    logic [tsr_pkg::SUM_W-1:0] sum_reg [2];
    logic [tsr_pkg::SUM_W-1:0] hs_reg  [2];
    logic [tsr_pkg::SUM_W-1:0] ls_reg  [2];
    logic [tsr_pkg::CNT_W-1:0] hn_reg  [2];
    logic [tsr_pkg::CNT_W-1:0] ln_reg  [2];
    logic [tsr_pkg::AB_W-1:0]  a_reg   [2];
    logic [tsr_pkg::AB_W-1:0]  b_reg   [2];
    logic [tsr_pkg::D_W-1:0]   d_reg   [2];
    logic                      zero_reg[2];
    logic [tsr_pkg::AB_W-1:0]  n_reg   [2];
    logic                      okl_reg [2];

    logic [tsr_pkg::P_W-1:0]   numer_reg;
    logic [tsr_pkg::P_W-1:0]   denom_reg;
    logic [tsr_pkg::RAT_W-1:0] q_reg;
    logic [tsr_pkg::P_W:0]     rem_reg;

    logic signed [tsr_pkg::CFG_W+tsr_pkg::LO_W:0] plo_reg;
    logic signed [tsr_pkg::CFG_W+tsr_pkg::HI_W:0] phi_reg;
    logic signed [tsr_pkg::ACC_W-1:0]             acc_reg;
    logic signed [tsr_pkg::CFG_W-1:0]             res_reg;
    logic signed [tsr_pkg::CFG_W-1:0]             turb_reg;
    logic                                         status_reg;

    logic [tsr_pkg::SAMPLE_W-1:0] cur    [2];
    logic [tsr_pkg::SUM_W-1:0]    scaled [2];
    logic [tsr_pkg::P_W:0]        rem_sh;
    logic signed [tsr_pkg::ACC_W-1:0] shifted;
    logic signed [tsr_pkg::ACC_W-1:0] total;

    // scan read and classification compare
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cur[l]    = win_reg[l][cmd.idx];
            scaled[l] = tsr_pkg::SUM_W'(cur[l]) * tsr_pkg::SUM_W'(tsr_pkg::WINDOW);
        end
    end

    // window storage and write slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < 2; l++) begin
                for (int i = 0; i < tsr_pkg::WINDOW; i++) begin
                    win_reg[l][i] <= '0;
                end
            end
            slot_reg <= '0;
        end else if (cmd.wr) begin
            win_reg[0][slot_reg] <= s_side_sample;
            win_reg[1][slot_reg] <= s_through_sample;
            slot_reg <= (slot_reg == tsr_pkg::IDX_W'(tsr_pkg::WINDOW - 1)) ? '0
                                                                            : slot_reg + 1'b1;
        end
    end

    // calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_reg <= tsr_pkg::CAL_SLOPE_RST;
            icpt_reg  <= tsr_pkg::CAL_INTERCEPT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                tsr_pkg::REG_CAL_SLOPE:     slope_reg <= cfg_data;
                tsr_pkg::REG_CAL_INTERCEPT: icpt_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sum, classify and spread fraction per lane
    always_ff @(posedge aclk) begin
        for (int l = 0; l < 2; l++) begin
            if (cmd.scan_clr) begin
                sum_reg[l] <= '0;
                hs_reg[l]  <= '0;
                ls_reg[l]  <= '0;
                hn_reg[l]  <= '0;
                ln_reg[l]  <= '0;
            end
            if (cmd.sum_en) begin
                sum_reg[l] <= sum_reg[l] + tsr_pkg::SUM_W'(cur[l]);
            end
            if (cmd.cls_en) begin
                if (scaled[l] > sum_reg[l]) begin
                    hs_reg[l] <= hs_reg[l] + tsr_pkg::SUM_W'(cur[l]);
                    hn_reg[l] <= hn_reg[l] + tsr_pkg::CNT_W'(1);
                end else begin
                    ls_reg[l] <= ls_reg[l] + tsr_pkg::SUM_W'(cur[l]);
                    ln_reg[l] <= ln_reg[l] + tsr_pkg::CNT_W'(1);
                end
            end
            if (cmd.ab_en) begin
                a_reg[l]    <= tsr_pkg::AB_W'(hs_reg[l]) * tsr_pkg::AB_W'(ln_reg[l]);
                b_reg[l]    <= tsr_pkg::AB_W'(ls_reg[l]) * tsr_pkg::AB_W'(hn_reg[l]);
                d_reg[l]    <= tsr_pkg::D_W'(hn_reg[l]) * tsr_pkg::D_W'(ln_reg[l]);
                zero_reg[l] <= (hn_reg[l] == '0) || (ln_reg[l] == '0);
            end
            if (cmd.nd_en) begin
                n_reg[l]   <= a_reg[l] - b_reg[l];
                okl_reg[l] <= !zero_reg[l] && (a_reg[l] > b_reg[l]);
            end
        end
    end

    assign sts.ok = okl_reg[0] && okl_reg[1];

    // cross products and restoring divider, one quotient bit per step
    assign rem_sh = {rem_reg[tsr_pkg::P_W-1:0], q_reg[tsr_pkg::RAT_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.pq_en) begin
            numer_reg <= tsr_pkg::P_W'(n_reg[0]) * tsr_pkg::P_W'(d_reg[1]);
            denom_reg <= tsr_pkg::P_W'(d_reg[0]) * tsr_pkg::P_W'(n_reg[1]);
        end
        if (cmd.div_load) begin
            q_reg   <= {numer_reg, {tsr_pkg::FRAC_W{1'b0}}};
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, denom_reg}) begin
                rem_reg <= rem_sh - {1'b0, denom_reg};
                q_reg   <= {q_reg[tsr_pkg::RAT_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[tsr_pkg::RAT_W-2:0], 1'b0};
            end
        end
    end

    // slope times ratio in two partial products, then offset and saturate
    assign shifted = acc_reg >>> tsr_pkg::FRAC_W;
    assign total   = shifted + tsr_pkg::ACC_W'(icpt_reg);

    always_ff @(posedge aclk) begin
        if (cmd.plo_en) begin
            plo_reg <= slope_reg * $signed({1'b0, q_reg[tsr_pkg::LO_W-1:0]});
        end
        if (cmd.phi_en) begin
            phi_reg <= slope_reg * $signed({1'b0, q_reg[tsr_pkg::RAT_W-1:tsr_pkg::LO_W]});
        end
        if (cmd.acc_en) begin
            acc_reg <= tsr_pkg::ACC_W'(plo_reg) + (tsr_pkg::ACC_W'(phi_reg) <<< tsr_pkg::LO_W);
        end
        if (cmd.res_en) begin
            if (total > SAT_HI) begin
                res_reg <= SAT_HI[tsr_pkg::CFG_W-1:0];
            end else if (total < SAT_LO) begin
                res_reg <= SAT_LO[tsr_pkg::CFG_W-1:0];
            end else begin
                res_reg <= total[tsr_pkg::CFG_W-1:0];
            end
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            turb_reg   <= cmd.out_err ? '0 : res_reg;
            status_reg <= cmd.out_err;
        end
    end

    assign m_turbidity = turb_reg;
    assign m_status    = status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsr_ctrl
// sequencer for scan, spread check, division and output handshake
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tsr_pkg::cmd_t      cmd,
    input  wire tsr_pkg::sts_t sts
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_CLS  = 4'd2;
    localparam logic [3:0] S_AB   = 4'd3;
    localparam logic [3:0] S_ND   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_DLD  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_PLO  = 4'd8;
    localparam logic [3:0] S_PHI  = 4'd9;
    localparam logic [3:0] S_ACC  = 4'd10;
    localparam logic [3:0] S_RES  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    localparam logic [tsr_pkg::IDX_W-1:0]  IDX_LAST = tsr_pkg::IDX_W'(tsr_pkg::WINDOW - 1);
    localparam logic [tsr_pkg::DCNT_W-1:0] DIV_LAST = tsr_pkg::DCNT_W'(tsr_pkg::RAT_W - 1);

    logic [3:0]                  state_reg, state_next;
    logic [tsr_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [tsr_pkg::DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic                        err_reg, err_next;
    logic                        m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        dcnt_next  = dcnt_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.out_err = err_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.wr       = 1'b1;
                    cmd.scan_clr = 1'b1;
                    idx_next     = '0;
                    state_next   = S_SUM;
                end
            end
            S_SUM: begin
                cmd.sum_en = 1'b1;
                if (idx_reg == IDX_LAST) begin
                    idx_next   = '0;
                    state_next = S_CLS;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CLS: begin
                cmd.cls_en = 1'b1;
                if (idx_reg == IDX_LAST) begin
                    idx_next   = '0;
                    state_next = S_AB;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_AB: begin
                cmd.ab_en  = 1'b1;
                state_next = S_ND;
            end
            S_ND: begin
                cmd.nd_en  = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (sts.ok) begin
                    cmd.pq_en  = 1'b1;
                    err_next   = 1'b0;
                    state_next = S_DLD;
                end else begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DLD: begin
                cmd.div_load = 1'b1;
                dcnt_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (dcnt_reg == DIV_LAST) begin
                    state_next = S_PLO;
                end else begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            S_PLO: begin
                cmd.plo_en = 1'b1;
                state_next = S_PHI;
            end
            S_PHI: begin
                cmd.phi_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = S_RES;
            end
            S_RES: begin
                cmd.res_en = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            dcnt_reg    <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            dcnt_reg    <= dcnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/turbidity_spread_ratio_top.sv =====
// A new request is accepted only in idle, after the previous result has been
// loaded into the output register; a window with no usable spread skips the divider.
// The two window scans and the one-bit-per-cycle restoring divider (RAT_W = 45
// steps) take most of the processing time of a request.
// Reset: synchronous active-low aresetn clears both windows, the write slot,
// the controller and the output valid; calibration returns to slope 1.0, offset 0.
// ----------------------------------------------------------------------------
// turbidity_spread_ratio_top
// side/through window spread ratio with calibrated saturated Q16.16 output
// ----------------------------------------------------------------------------
`default_nettype none

`include "turbidity_spread_ratio_top_macros.svh"

module turbidity_spread_ratio_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tsr_pkg::SAMPLE_W-1:0]  s_side_sample,
    input  wire logic [tsr_pkg::SAMPLE_W-1:0]  s_through_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [tsr_pkg::CFG_W-1:0]   m_turbidity,
    output logic                               m_status,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [tsr_pkg::CFG_W-1:0]     cfg_data
);

    tsr_pkg::cmd_t cmd;
    tsr_pkg::sts_t sts;

    // sequencer
    tsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // arithmetic and storage
    tsr_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_side_sample    (s_side_sample),
        .s_through_sample (s_through_sample),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_turbidity      (m_turbidity),
        .m_status         (m_status)
    );

    // one request in flight at a time
    `TSR_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // an error result always carries zero turbidity
    `TSR_ASSERT_IMPLY(a_err_zero, aclk, aresetn, m_valid && m_status, m_turbidity == '0)
    // a new result never overwrites one still waiting
    `TSR_ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, cmd.out_load, !(m_valid && !m_ready))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives side/through sample pairs with random idling on both channels, runs
// an independent window spread-ratio predictor and checks every result in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int NWIN      = 16;
    localparam int RAND_REQS = 1000;
    localparam int TAIL_REQS = 200;
    localparam int SETTLE    = 120;
    localparam longint LIMIT = 1_000_000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [tsr_pkg::SAMPLE_W-1:0] s_side_sample = '0;
    logic [tsr_pkg::SAMPLE_W-1:0] s_through_sample = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [tsr_pkg::CFG_W-1:0] m_turbidity;
    logic                m_status;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [tsr_pkg::CFG_W-1:0]    cfg_data = '0;

    // predictor state
    logic [9:0]          side_win [NWIN];
    logic [9:0]          thru_win [NWIN];
    int unsigned         slot;
    longint              slope_q;
    longint              icept_q;

    // expected turbidity and status, in order
    logic signed [31:0]  exp_turb_q [$];
    logic                exp_stat_q [$];

    int                  errors = 0;
    longint              cycles = 0;
    bit                  quiet = 1'b0;
    int                  stall_left = 0;

    turbidity_spread_ratio_top uut (.*);

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // spread of one window as a fraction; zero on no usable spread
    function automatic bit spread_of(input logic [9:0] w [NWIN],
                                     output longint num, output longint den);
        longint sum, hs, ls, hn, ln, a, b;
        sum = 0; hs = 0; ls = 0; hn = 0; ln = 0;
        num = 0; den = 0;
        for (int i = 0; i < NWIN; i++) sum += w[i];
        for (int i = 0; i < NWIN; i++) begin
            if (longint'(w[i]) * NWIN > sum) begin
                hs += w[i]; hn++;
            end else begin
                ls += w[i]; ln++;
            end
        end
        if (hn == 0 || ln == 0) return 1'b0;
        a = hs * ln;
        b = ls * hn;
        if (a <= b) return 1'b0;
        num = a - b;
        den = hn * ln;
        return 1'b1;
    endfunction

    // update windows and predict one turbidity result
    task automatic predict_turbidity(input logic [9:0] sv, input logic [9:0] tv);
        longint n90, d90, n180, d180, ratio, rint, rfrac, prod, p, res;
        bit ok90, ok180;
        side_win[slot] = sv;
        thru_win[slot] = tv;
        slot = (slot + 1) % NWIN;
        ok90 = spread_of(side_win, n90, d90);
        ok180 = spread_of(thru_win, n180, d180);
        if (!ok90 || !ok180) begin
            exp_turb_q.push_back(32'sd0);
            exp_stat_q.push_back(1'b1);
        end else begin
            ratio = ((n90 * d180) <<< 16) / (d90 * n180);
            rint = ratio >>> 16;
            rfrac = ratio & 64'hFFFF;
            prod = slope_q * rint;
            p = slope_q * rfrac;
            if (p >= 0) prod += p / 65536;
            else prod -= (-p + 65535) / 65536;
            res = prod + icept_q;
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            exp_turb_q.push_back(res[31:0]);
            exp_stat_q.push_back(1'b0);
        end
    endtask

    // random idle burst before a request, sometimes
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    // one sample-pair request
    task automatic send_sample(input logic [9:0] sv, input logic [9:0] tv);
        maybe_idle();
        s_valid <= 1'b1;
        s_side_sample <= sv;
        s_through_sample <= tv;
        predict_turbidity(sv, tv);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (exp_turb_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // calibration write, only while idle
    task automatic write_cal(input logic idx, input logic [31:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == tsr_pkg::REG_CAL_SLOPE) slope_q = longint'(signed'(val));
        else icept_q = longint'(signed'(val));
    endtask

    // result stall pattern, random bursts of m_ready low
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left <= int'($urandom_range(0, 5));
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_turb_q.size() == 0) begin
                $error("unexpected result turbidity %0d", m_turbidity);
                errors++;
            end else begin
                if (m_turbidity !== exp_turb_q[0]) begin
                    $error("turbidity exp %0d got %0d", exp_turb_q[0], m_turbidity);
                    errors++;
                end
                if (m_status !== exp_stat_q[0]) begin
                    $error("status exp %0b got %0b", exp_stat_q[0], m_status);
                    errors++;
                end
                void'(exp_turb_q.pop_front());
                void'(exp_stat_q.pop_front());
            end
        end
    end

    // extremes and special cases at reset calibration
    task automatic test_directed();
        send_sample(10'd0, 10'd0);           // all equal: no high entries
        send_sample(10'd1023, 10'd1023);
        send_sample(10'd1023, 10'd0);        // full-scale side sample, zero through sample
        send_sample(10'd0, 10'd1023);
        for (int i = 0; i < 6; i++)
            send_sample(10'(i * 200), 10'(1023 - i * 150));
        send_sample(10'h2AA, 10'h155);
        send_sample(10'h155, 10'h2AA);
        send_sample(10'd1, 10'd1023);
        send_sample(10'd1023, 10'd1);
    endtask

    // calibration extremes, saturation both ways
    task automatic test_calibration();
        logic [31:0] slopes [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h0};
        logic [31:0] icepts [3] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000};
        for (int k = 0; k < 4; k++) begin
            write_cal(tsr_pkg::REG_CAL_SLOPE, slopes[k]);
            write_cal(tsr_pkg::REG_CAL_INTERCEPT, icepts[k % 3]);
            for (int i = 0; i < 20; i++)
                send_sample(10'($urandom), 10'($urandom));
        end
        write_cal(tsr_pkg::REG_CAL_SLOPE, 32'h0001_0000);
        write_cal(tsr_pkg::REG_CAL_INTERCEPT, 32'h0);
    endtask

    // random samples, mostly spread-out windows, some flat runs
    task automatic test_random(input int n);
        logic [9:0] a, b;
        for (int i = 0; i < n; i++) begin
            if (i % 300 == 150) begin
                write_cal(tsr_pkg::REG_CAL_SLOPE, $urandom);
                write_cal(tsr_pkg::REG_CAL_INTERCEPT,
                          $urandom_range(0, 3) == 0 ? $urandom : 32'h0);
            end
            case ($urandom_range(0, 9))
                0: begin a = 10'd512; b = 10'd512; end
                1: begin
                    a = 10'($urandom_range(0, 3));
                    b = 10'($urandom_range(1020, 1023));
                end
                default: begin a = 10'($urandom); b = 10'($urandom); end
            endcase
            send_sample(a, b);
        end
    endtask

    // sender waits for every outstanding result
    task automatic test_hold_off();
        wait_drained();
        for (int i = 0; i < 10; i++) send_sample(10'($urandom), 10'($urandom));
    endtask

    initial begin
        for (int i = 0; i < NWIN; i++) begin
            side_win[i] = '0;
            thru_win[i] = '0;
        end
        slot = 0;
        slope_q = 65536;
        icept_q = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_calibration();
        test_hold_off();
        test_random(RAND_REQS);
        quiet = 1'b1;
        test_random(TAIL_REQS);
        wait_drained();
        if (errors == 0 && exp_turb_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tsr_pkg.sv
rtl/core/tsr_dp.sv
rtl/core/tsr_ctrl.sv
rtl/core/turbidity_spread_ratio_top.sv
tb/tb_top.sv
